>>> hdl/h264_start_code_nal_splitter_top_macros.svh
// Assertion macros used by the checker of the start code splitter.
`ifndef H264_START_CODE_NAL_SPLITTER_TOP_MACROS_SVH
`define H264_START_CODE_NAL_SPLITTER_TOP_MACROS_SVH

// Implication that is checked only while the block is out of reset.
`define H264_ASSERT_RUN(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("start code splitter check failed");

// Implication checked in the next cycle, only while out of reset.
`define H264_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("start code splitter check failed");

// Implication checked in the next cycle that is also checked while reset is applied.
`define H264_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) (ante) |=> (cons)) \
    else $error("start code splitter check failed");

`endif

>>> hdl/h264_sc_pkg.sv
// Package with the types and constants of the start code splitter.
`timescale 1ns / 1ps
package h264_sc_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1048576;
  localparam int unsigned FIELD_POS_LIMIT = 1048576;
  localparam int unsigned POS_CAP_INT =
      (MAX_PACKET_BYTES > FIELD_POS_LIMIT) ? FIELD_POS_LIMIT :
      ((MAX_PACKET_BYTES < 1) ? 1 : MAX_PACKET_BYTES);

  localparam int BYTE_W = 8;
  localparam int TYPE_W = 5;
  localparam int OFFS_W = 20;
  localparam int POS_W = 21;
  localparam int ZRUN_W = 2;

  localparam logic [POS_W-1:0] POS_CAP = POS_W'(POS_CAP_INT);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FIELD_POS_LIMIT);

  localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
  localparam logic [BYTE_W-1:0] START_BYTE = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;
  localparam logic [ZRUN_W-1:0] ZRUN_MAX = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = 2;
  localparam int FIFO_CW = 3;

  typedef struct packed {
    logic [TYPE_W-1:0] unit_type;
    logic [OFFS_W-1:0] start_pos;
    logic [POS_W-1:0]  stop_pos;
    logic              last;
    logic              clipped;
  } desc_t;

endpackage

>>> hdl/h264_start_code_nal_splitter_top.sv
// Top level of the H.264 Annex B start code splitter.
//
//   Channel   Direction  Handshake      Payload
//   bytes     in         push / full    stream_byte_i, packet_end_i
//   units     out        empty / pop    unit_type_o, unit_offset_o, unit_length_o,
//                                       packet_last_unit_o, length_clipped_o
//
// The parser takes one byte per clock while full is low; its state registers close the loop.
// A closed unit is written into the descriptor queue and from there into the output register,
// which drives the result ports, when the output register is free.
// Four descriptors queue between parser and output register; full rises only when it fills.
// Reset clears all parser and queue control state at once; no clearing pass is needed.
`timescale 1ns / 1ps
module h264_start_code_nal_splitter_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic [h264_sc_pkg::BYTE_W-1:0]     stream_byte_i,
  input  logic                               packet_end_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [h264_sc_pkg::TYPE_W-1:0]     unit_type_o,
  output logic [h264_sc_pkg::OFFS_W-1:0]     unit_offset_o,
  output logic [h264_sc_pkg::POS_W-1:0]      unit_length_o,
  output logic                               packet_last_unit_o,
  output logic                               length_clipped_o
);
  import h264_sc_pkg::*;

  logic  take_byte;
  logic  desc_valid;
  desc_t desc;
  logic  q_valid;
  desc_t q_data;
  logic  q_take;

  assign take_byte = push && !full;

  h264_sc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take_byte),
    .stream_byte_i (stream_byte_i),
    .packet_end_i  (packet_end_i),
    .desc_valid_o  (desc_valid),
    .desc_o        (desc)
  );

  h264_sc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_valid),
    .data_i  (desc),
    .full_o  (full),
    .pop_i   (q_take),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  h264_sc_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (q_valid),
    .data_i             (q_data),
    .take_o             (q_take),
    .pop                (pop),
    .empty              (empty),
    .unit_type_o        (unit_type_o),
    .unit_offset_o      (unit_offset_o),
    .unit_length_o      (unit_length_o),
    .packet_last_unit_o (packet_last_unit_o),
    .length_clipped_o   (length_clipped_o)
  );

endmodule

>>> hdl/h264_sc_front.sv
// Byte parser that tracks start codes and closes NAL units.
`timescale 1ns / 1ps
module h264_sc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                take_i,
  input  logic [h264_sc_pkg::BYTE_W-1:0]      stream_byte_i,
  input  logic                                packet_end_i,
  output logic                                desc_valid_o,
  output h264_sc_pkg::desc_t                  desc_o
);
  import h264_sc_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [ZRUN_W-1:0] zrun_q, zrun_d;
  logic              open_q, open_d;
  logic              hexp_q, hexp_d;
  logic [OFFS_W-1:0] start_q, start_d;
  logic [TYPE_W-1:0] type_q, type_d;
  logic              sat_q, sat_d;

  always_comb begin
    pos_d = pos_q;
    zrun_d = zrun_q;
    open_d = open_q;
    hexp_d = hexp_q;
    start_d = start_q;
    type_d = type_q;
    sat_d = sat_q;
    desc_valid_o = 1'b0;
    desc_o = '0;
    if (take_i) begin
      if (pos_q >= POS_CAP) begin
        sat_d = 1'b1;
        pos_d = POS_CAP;
        if (packet_end_i) begin
          if (open_q) begin
            desc_valid_o = 1'b1;
            desc_o = '{type_q, start_q, POS_CAP, 1'b1, 1'b1};
          end
          pos_d = '0;
          zrun_d = '0;
          open_d = 1'b0;
          hexp_d = 1'b0;
          start_d = '0;
          type_d = '0;
          sat_d = 1'b0;
        end
      end else begin
        if (hexp_q) begin
          start_d = pos_q[OFFS_W-1:0];
          type_d = TYPE_W'(stream_byte_i & TYPE_MASK);
          open_d = 1'b1;
          hexp_d = 1'b0;
        end else if (stream_byte_i == START_BYTE && zrun_q == ZRUN_MAX) begin
          if (open_q) begin
            desc_valid_o = 1'b1;
            desc_o = '{type_q, start_q, pos_q - POS_W'(2), packet_end_i, sat_q};
          end
          open_d = 1'b0;
          hexp_d = 1'b1;
        end
        if (stream_byte_i == ZERO_BYTE) begin
          if (zrun_q < ZRUN_MAX) begin
            zrun_d = zrun_q + ZRUN_W'(1);
          end
        end else begin
          zrun_d = '0;
        end
        if (packet_end_i) begin
          if (!desc_valid_o && open_d) begin
            desc_valid_o = 1'b1;
            desc_o = '{type_d, start_d, pos_q + POS_W'(1), 1'b1, sat_q};
          end
          pos_d = '0;
          zrun_d = '0;
          open_d = 1'b0;
          hexp_d = 1'b0;
          start_d = '0;
          type_d = '0;
          sat_d = 1'b0;
        end else begin
          pos_d = pos_q + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      zrun_q <= '0;
      open_q <= 1'b0;
      hexp_q <= 1'b0;
      start_q <= '0;
      type_q <= '0;
      sat_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      zrun_q <= zrun_d;
      open_q <= open_d;
      hexp_q <= hexp_d;
      start_q <= start_d;
      type_q <= type_d;
      sat_q <= sat_d;
    end
  end

endmodule

>>> hdl/h264_sc_fifo.sv
// Short descriptor queue between the parser and the output stage.
`timescale 1ns / 1ps
module h264_sc_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  h264_sc_pkg::desc_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output h264_sc_pkg::desc_t data_o
);
  import h264_sc_pkg::*;

  desc_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q;
  logic               do_push, do_pop;

  assign full_o = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - FIFO_CW'(1);
      end
    end
  end

endmodule

>>> hdl/h264_sc_back.sv
// Output stage that forms the unit length and holds the result for the reader.
`timescale 1ns / 1ps
module h264_sc_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  h264_sc_pkg::desc_t                 data_i,
  output logic                               take_o,
  input  logic                               pop,
  output logic                               empty,
  output logic [h264_sc_pkg::TYPE_W-1:0]     unit_type_o,
  output logic [h264_sc_pkg::OFFS_W-1:0]     unit_offset_o,
  output logic [h264_sc_pkg::POS_W-1:0]      unit_length_o,
  output logic                               packet_last_unit_o,
  output logic                               length_clipped_o
);
  import h264_sc_pkg::*;

  logic             vld_q;
  logic [POS_W-1:0] start_ext;
  logic [POS_W-1:0] len_d;

  assign take_o = valid_i && (!vld_q || pop);
  assign empty = !vld_q;
  assign start_ext = {1'b0, data_i.start_pos};
  assign len_d = (data_i.stop_pos >= start_ext) ? (data_i.stop_pos - start_ext) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take_o) begin
      vld_q <= 1'b1;
    end else if (pop) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      unit_type_o <= data_i.unit_type;
      unit_offset_o <= data_i.start_pos;
      unit_length_o <= len_d;
      packet_last_unit_o <= data_i.last;
      length_clipped_o <= data_i.clipped;
    end
  end

endmodule

>>> hdl/h264_sc_checker.sv
// Port level checker of the start code splitter and its bind statement.
`timescale 1ns / 1ps
`include "h264_start_code_nal_splitter_top_macros.svh"
module h264_sc_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic [h264_sc_pkg::BYTE_W-1:0]     stream_byte_i,
  input logic                               packet_end_i,
  input logic                               empty,
  input logic                               pop,
  input logic [h264_sc_pkg::TYPE_W-1:0]     unit_type_o,
  input logic [h264_sc_pkg::OFFS_W-1:0]     unit_offset_o,
  input logic [h264_sc_pkg::POS_W-1:0]      unit_length_o,
  input logic                               packet_last_unit_o,
  input logic                               length_clipped_o
);
  import h264_sc_pkg::*;

  logic [POS_W:0] unit_end;
  logic           in_unused;

  assign unit_end = {2'b00, unit_offset_o} + {1'b0, unit_length_o};
  assign in_unused = push ^ (^stream_byte_i) ^ packet_end_i;

  `H264_ASSERT_ALWAYS(a_reset_empty, !rst_ni, empty && !full)
  `H264_ASSERT_NEXT(a_result_held, !empty && !pop,
      !empty && $stable(unit_type_o) && $stable(unit_offset_o) && $stable(unit_length_o))
  `H264_ASSERT_RUN(a_unit_in_packet, !empty, unit_end <= {1'b0, POS_LIMIT} || in_unused)
  `H264_ASSERT_RUN(a_clip_at_end, !empty && length_clipped_o, packet_last_unit_o)

endmodule

bind h264_start_code_nal_splitter_top h264_sc_checker u_h264_sc_checker (.*);
